// ----- hdl/threshold_peak_picker_macros.svh -----
// assertion macros shared by the peak picker checks
`ifndef THRESHOLD_PEAK_PICKER_MACROS_SVH
`define THRESHOLD_PEAK_PICKER_MACROS_SVH

// same-cycle implication, inactive while reset is asserted
`define THPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive while reset is asserted
`define THPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define THPP_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/thpp_pkg.sv -----
// types and constants of the threshold peak picker
`timescale 1ns / 1ps
`default_nettype none

package thpp_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PEAK_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_MIN_GAP        = 2'd1;
    localparam t_cfg_idx CFG_MAX_GAP        = 2'd2;

    // reset values before masking to the configured widths
    localparam logic [31:0] THRESHOLD_RST_VALUE = 32'd32768;
    localparam logic [31:0] MIN_GAP_RST_VALUE   = 32'd1;
    localparam logic [31:0] MAX_GAP_RST_VALUE   = 32'h00FF_FFFF;

    localparam logic [1:0] WINDOW_FULL = 2'd2;

    typedef struct packed {
        logic level_ok;
        logic gap_ok;
    } t_pick_ctl;

endpackage

`default_nettype wire

// ----- hdl/thpp_pick.sv -----
// local maximum test and peak spacing test for one candidate
`timescale 1ns / 1ps
`default_nettype none

module thpp_pick
    import thpp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAME_BITS  = 24
) (
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_older,
    input  wire logic [SAMPLE_BITS-1:0] i_middle,
    input  wire logic [SAMPLE_BITS-1:0] i_threshold,
    input  wire logic                   i_window_ok,
    input  wire logic [FRAME_BITS-1:0]  i_cand_frame,
    input  wire logic [FRAME_BITS-1:0]  i_last_frame,
    input  wire logic                   i_peak_seen,
    input  wire logic [FRAME_BITS-1:0]  i_min_gap,
    input  wire logic [FRAME_BITS-1:0]  i_max_gap,
    output t_pick_ctl                   o_ctl
);

    logic [FRAME_BITS-1:0] delta;

    always_comb begin
        // distance clamps at zero if the last peak lies ahead
        delta = (i_cand_frame >= i_last_frame) ? (i_cand_frame - i_last_frame) : '0;

        o_ctl.level_ok = i_window_ok
                      && (i_middle >= i_threshold)
                      && (i_middle >= i_older)
                      && (i_middle >= i_sample);

        o_ctl.gap_ok = !i_peak_seen
                    || ((delta >= i_min_gap) && (delta <= i_max_gap))
                    || (delta > i_max_gap);
    end

endmodule

`default_nettype wire

// ----- hdl/threshold_peak_picker.sv -----
// streaming local maximum peak picker with min and max peak spacing
// an accepted request's peak, if any, is registered and shows at o_out_valid and o_peak_frame
// throughput: one request per cycle; o_in_ready drops only while a peak waits on i_out_ready
// the single output register is the only buffer, so a stalled peak holds the input side
// reset: synchronous active low, clears the window, frame counter, peak history and output valid
// reset: threshold, min gap and max gap return to 32768, 1 and 0x00FFFFFF (masked to width)
`timescale 1ns / 1ps
`default_nettype none

module threshold_peak_picker
    import thpp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAME_BITS  = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire t_cfg_idx               i_cfg_idx,
    input  wire logic [((SAMPLE_BITS > FRAME_BITS) ? SAMPLE_BITS : FRAME_BITS)-1:0] i_cfg_data,
    // sample requests
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_start_req,
    // accepted peaks
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [FRAME_BITS-1:0]       o_peak_frame
);

    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(THRESHOLD_RST_VALUE);
    localparam logic [FRAME_BITS-1:0]  MIN_GAP_RST   = FRAME_BITS'(MIN_GAP_RST_VALUE);
    localparam logic [FRAME_BITS-1:0]  MAX_GAP_RST   = FRAME_BITS'(MAX_GAP_RST_VALUE);

    // configuration registers
    logic [SAMPLE_BITS-1:0] r_threshold;
    logic [FRAME_BITS-1:0]  r_min_gap;
    logic [FRAME_BITS-1:0]  r_max_gap;

    // sequence state
    logic [SAMPLE_BITS-1:0] r_older, n_older;
    logic [SAMPLE_BITS-1:0] r_middle, n_middle;
    logic [1:0]             r_fill, n_fill;
    logic [FRAME_BITS-1:0]  r_count, n_count;
    logic [FRAME_BITS-1:0]  r_last, n_last;
    logic                   r_seen, n_seen;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [FRAME_BITS-1:0]  r_peak_frame, n_peak_frame;

    // state as seen by this request, after a start request clears it
    logic [SAMPLE_BITS-1:0] cur_older;
    logic [SAMPLE_BITS-1:0] cur_middle;
    logic [1:0]             cur_fill;
    logic [FRAME_BITS-1:0]  cur_count;
    logic [FRAME_BITS-1:0]  cur_last;
    logic                   cur_seen;
    logic [FRAME_BITS-1:0]  cand_frame;
    logic                   window_ok;
    logic                   in_fire;
    logic                   peak_hit;
    t_pick_ctl              pick_ctl;

    // output register frees up in the same cycle it is taken
    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign in_fire      = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_peak_frame = r_peak_frame;

    always_comb begin
        cur_older  = i_start_req ? '0 : r_older;
        cur_middle = i_start_req ? '0 : r_middle;
        cur_fill   = i_start_req ? '0 : r_fill;
        cur_count  = i_start_req ? '0 : r_count;
        cur_last   = i_start_req ? '0 : r_last;
        cur_seen   = i_start_req ? 1'b0 : r_seen;

        // candidate is the middle sample, one frame behind the incoming one
        window_ok  = (cur_fill == WINDOW_FULL) && (cur_count != '0);
        cand_frame = cur_count - FRAME_BITS'(1);
    end

    thpp_pick #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_pick (
        .i_sample     (i_sample),
        .i_older      (cur_older),
        .i_middle     (cur_middle),
        .i_threshold  (r_threshold),
        .i_window_ok  (window_ok),
        .i_cand_frame (cand_frame),
        .i_last_frame (cur_last),
        .i_peak_seen  (cur_seen),
        .i_min_gap    (r_min_gap),
        .i_max_gap    (r_max_gap),
        .o_ctl        (pick_ctl)
    );

    assign peak_hit = pick_ctl.level_ok && pick_ctl.gap_ok;

    always_comb begin
        n_older      = r_older;
        n_middle     = r_middle;
        n_fill       = r_fill;
        n_count      = r_count;
        n_last       = r_last;
        n_seen       = r_seen;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_peak_frame = r_peak_frame;

        if (in_fire) begin
            // shift the two-sample window
            n_older  = cur_middle;
            n_middle = i_sample;
            n_fill   = (cur_fill == WINDOW_FULL) ? cur_fill : cur_fill + 2'd1;
            // frame counter sticks at its top value
            n_count  = (cur_count == '1) ? cur_count : cur_count + FRAME_BITS'(1);
            n_last   = cur_last;
            n_seen   = cur_seen;
            if (peak_hit) begin
                n_last       = cand_frame;
                n_seen       = 1'b1;
                n_out_valid  = 1'b1;
                n_peak_frame = cand_frame;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_min_gap   <= MIN_GAP_RST;
            r_max_gap   <= MAX_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PEAK_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MIN_GAP:        r_min_gap   <= i_cfg_data[FRAME_BITS-1:0];
                CFG_MAX_GAP:        r_max_gap   <= i_cfg_data[FRAME_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // sequence state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_middle    <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_older     <= n_older;
            r_middle    <= n_middle;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    // peak frame payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_peak_frame <= n_peak_frame;
    end

endmodule

`default_nettype wire

// ----- hdl/thpp_checker.sv -----
// port-level checks for the threshold peak picker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "threshold_peak_picker_macros.svh"

module thpp_checker #(
    parameter int FRAME_BITS = 24
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  i_start_req,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [FRAME_BITS-1:0] o_peak_frame
);

    // a held peak keeps its frame index
    `THPP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_peak_frame), "peak dropped or changed while stalled")

    // empty output register never stalls the input side
    `THPP_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready, "input stalled with no peak pending")

    // a start request is frame 0, it never yields a new peak
    `THPP_ASSERT_NEXT(a_start_no_peak, i_in_valid && o_in_ready && i_start_req, !o_out_valid || $past(o_out_valid && !i_out_ready), "peak reported for a start request")

    // reset empties the output register
    `THPP_ASSERT_ALWAYS_NEXT(a_reset_clears, !i_rst_n, !o_out_valid, "peak valid right after reset")

endmodule

bind threshold_peak_picker thpp_checker #(
    .FRAME_BITS (FRAME_BITS)
) u_thpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_start_req  (i_start_req),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_peak_frame (o_peak_frame)
);

`default_nettype wire

// ----- verif/tb_threshold_peak_picker.sv -----
// self-checking testbench for the threshold peak picker with its own peak predictor
`timescale 1ns / 1ps

module tb_threshold_peak_picker;
    import thpp_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam int FRAME_W        = 24;
    localparam int CFG_W          = (SAMPLE_W > FRAME_W) ? SAMPLE_W : FRAME_W;
    localparam int SETTLE_CYCLES  = 4;     // idle wait at the end of drain(), after the registered output
    localparam int WATCHDOG_LIMIT = 3000;  // well above the longest receiver hold-off

    // one sample request as the sender offers it
    typedef struct {
        logic [SAMPLE_W-1:0] level;
        logic                restart;
    } t_frame_req;

    // clock, reset and block inputs, all known from time zero
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    t_cfg_idx            cfg_idx  = CFG_PEAK_THRESHOLD;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic [SAMPLE_W-1:0] sample   = '0;
    logic                start    = 1'b0;
    logic                out_ready = 1'b0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [FRAME_W-1:0]  o_peak_frame;

    threshold_peak_picker #(
        .SAMPLE_BITS (SAMPLE_W),
        .FRAME_BITS  (FRAME_W)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (sample),
        .i_start_req  (start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_peak_frame (o_peak_frame)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // requests waiting for the driver and peak frames waiting for the block
    t_frame_req          pending[$];
    logic [FRAME_W-1:0]  peaks_due[$];
    int                  errors = 0;

    // predictor copy of the registers
    logic [SAMPLE_W-1:0] level_floor = THRESHOLD_RST_VALUE[SAMPLE_W-1:0];
    logic [FRAME_W-1:0]  gap_lo      = MIN_GAP_RST_VALUE[FRAME_W-1:0];
    logic [FRAME_W-1:0]  gap_hi      = MAX_GAP_RST_VALUE[FRAME_W-1:0];

    // predictor copy of the sliding window and the peak history
    logic [SAMPLE_W-1:0] old_level  = '0;
    logic [SAMPLE_W-1:0] mid_level  = '0;
    logic [1:0]          fill       = '0;
    logic [FRAME_W-1:0]  frame_no   = '0;
    logic [FRAME_W-1:0]  prior_peak = '0;
    logic                have_peak  = 1'b0;

    // advance the predicted window by one sample, queue the peak it reveals
    function automatic void track_peak(logic [SAMPLE_W-1:0] level, logic restart);
        logic [FRAME_W-1:0] cand;
        logic [FRAME_W-1:0] spacing;
        logic               take;
        if (restart) begin
            old_level  = '0;
            mid_level  = '0;
            fill       = '0;
            frame_no   = '0;
            prior_peak = '0;
            have_peak  = 1'b0;
        end
        // the middle sample is judged now that its right neighbor is here
        if (fill == WINDOW_FULL && frame_no != '0) begin
            cand = frame_no - 1'b1;
            if (mid_level >= level_floor && mid_level >= old_level && mid_level >= level) begin
                if (!have_peak) begin
                    take = 1'b1;
                end else begin
                    spacing = (cand >= prior_peak) ? cand - prior_peak : '0;
                    // inside the regular spacing, or past it as a restart
                    take = (spacing >= gap_lo && spacing <= gap_hi) || spacing > gap_hi;
                end
                if (take) begin
                    prior_peak = cand;
                    have_peak  = 1'b1;
                    peaks_due.insert(peaks_due.size(), cand);
                end
            end
        end
        old_level = mid_level;
        mid_level = level;
        if (fill < WINDOW_FULL) fill++;
        // frame counter saturates at all ones
        if (frame_no != '1) frame_no++;
    endfunction

    // ---------------------------------------------------------------
    // driver: one request at a time, random gap after each
    // ---------------------------------------------------------------
    int         send_wait  = 0;
    int         sent_count = 0;
    logic       send_calm  = 1'b0;
    t_frame_req next_req;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                track_peak(sample, start);
            end
            // valid holds with its payload until the request is taken
            if (!in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    next_req = pending.pop_front();
                    in_valid <= 1'b1;
                    sample   <= next_req.level;
                    start    <= next_req.restart;
                    sent_count++;
                    // switch between gap-free stretches and random gaps
                    if (sent_count % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
                    send_wait = send_calm ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: compare each accepted peak with the oldest prediction
    // ---------------------------------------------------------------
    int   recv_wait  = 0;
    int   hold_left  = 0;
    int   peaks_seen = 0;
    logic recv_calm  = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (peaks_due.size() == 0) begin
                    $display("%0t: unexpected peak, expected none, actual %0d",
                             $time, o_peak_frame);
                    errors++;
                end else if (o_peak_frame !== peaks_due[0]) begin
                    $display("%0t: peak_frame mismatch, expected %0d, actual %0d",
                             $time, peaks_due[0], o_peak_frame);
                    errors++;
                    void'(peaks_due.pop_front());
                end else begin
                    void'(peaks_due.pop_front());
                end
                peaks_seen++;
                if (peaks_seen % 16 == 0) recv_calm = ($urandom_range(0, 3) == 0);
                recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
                // long hold-off now and then so the output register backs up the input
                if (peaks_seen % 150 == 20) hold_left = $urandom_range(80, 160);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake or register write
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_threshold_peak_picker failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] prev_level = '0;

    task automatic push_req(logic [SAMPLE_W-1:0] level, logic restart);
        t_frame_req req;
        req.level   = level;
        req.restart = restart;
        pending.insert(pending.size(), req);
    endtask

    // register write, mirrored into the predictor while the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_PEAK_THRESHOLD: level_floor = value[SAMPLE_W-1:0];
            CFG_MIN_GAP:        gap_lo      = value[FRAME_W-1:0];
            CFG_MAX_GAP:        gap_hi      = value[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] lo,
                            logic [CFG_W-1:0] hi);
        write_reg(CFG_PEAK_THRESHOLD, thr);
        write_reg(CFG_MIN_GAP, lo);
        write_reg(CFG_MAX_GAP, hi);
        @(negedge clk);
    endtask

    // wait for every request taken and every peak back, then let the pipe settle
    task automatic drain();
        do @(negedge clk);
        while (pending.size() != 0 || in_valid || peaks_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sample level mix: full range, around the threshold, plateaus and rails
    function automatic logic [SAMPLE_W-1:0] pick_level();
        int near;
        logic [SAMPLE_W-1:0] lvl;
        case ($urandom_range(0, 9))
            0, 1, 2: lvl = SAMPLE_W'($urandom_range(0, 65535));
            3, 4, 5: begin
                near = int'(level_floor) + $urandom_range(0, 6) - 3;
                if (near < 0) near = 0;
                if (near > 65535) near = 65535;
                lvl = near[SAMPLE_W-1:0];
            end
            6, 7:    lvl = prev_level;
            8:       lvl = '1;
            default: lvl = '0;
        endcase
        prev_level = lvl;
        return lvl;
    endfunction

    // sequences that open with a start request, of mostly moderate length
    task automatic queue_run(int count);
        int left;
        left = 0;
        repeat (count) begin
            if (left == 0) begin
                left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 60);
                push_req(pick_level(), 1'b1);
            end else begin
                push_req(pick_level(), 1'b0);
            end
            left--;
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings: threshold half scale, gaps 1 and all ones
        push_req(16'h0000, 1'b1);
        push_req(16'h8000, 1'b0);   // level exactly at threshold, first peak
        push_req(16'h7FFF, 1'b0);
        push_req(16'hFFFF, 1'b0);   // just below threshold in the middle, no peak
        push_req(16'hFFFF, 1'b0);   // flat top, peaks on every frame of it
        push_req(16'hFFFF, 1'b0);
        push_req(16'h0000, 1'b0);
        push_req(16'h8001, 1'b0);
        push_req(16'h8000, 1'b0);
        push_req(16'hFFFF, 1'b0);   // last sample before a restart never judged
        push_req(16'hFFFF, 1'b1);   // restart clears history, no peak here
        push_req(16'hFFFF, 1'b0);   // window not yet full
        push_req(16'h0000, 1'b0);
        push_req(16'h1234, 1'b1);   // back to back restarts
        push_req(16'hFFFF, 1'b1);
        push_req(16'h0000, 1'b0);
        push_req(16'h5555, 1'b0);
        push_req(16'hAAAA, 1'b0);
        push_req(16'h5555, 1'b0);
        push_req(16'hAAAA, 1'b0);
        push_req(16'h0000, 1'b0);
        push_req(16'hFFFF, 1'b0);
        push_req(16'hFFFE, 1'b0);
        drain();

        // every local maximum is a peak: zero threshold, zero gaps
        set_regs('0, '0, '0);
        queue_run(150);
        drain();

        // top threshold with junk above the field, gaps at all ones:
        // only the first peak of each sequence gets through
        set_regs({8'hA5, 16'hFFFF}, '1, '1);
        queue_run(120);
        drain();

        // min gap above max gap: only spacings past max gap count
        set_regs({8'h3C, 16'h8000}, 24'd10, 24'd3);
        queue_run(150);
        drain();

        repeat (8) begin
            set_regs(CFG_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16777215)
                                                      : $urandom_range(0, 65535)),
                     CFG_W'($urandom_range(0, 8)),
                     $urandom_range(0, 4) == 0 ? CFG_W'(24'hFFFFFF)
                                               : CFG_W'($urandom_range(0, 16)));
            queue_run(140);
            drain();
        end

        if (errors == 0 && peaks_due.size() == 0) begin
            $display("tb_threshold_peak_picker passed");
        end else begin
            $display("tb_threshold_peak_picker failed");
        end
        $finish;
    end

endmodule
